>>> src/sumc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sumc_pkg
// Shared constants, result codes and helpers of the segmented machine core.
// ----------------------------------------------------------------------------
package sumc_pkg;

    localparam int SEG_COUNT = 128;
    localparam int SEG_WORDS = 4096;
    localparam int REG_COUNT = 8;

    localparam int WORD_W = 32;
    localparam int ID_W   = $clog2(SEG_COUNT);
    localparam int OFF_W  = $clog2(SEG_WORDS);
    localparam int LEN_W  = OFF_W + 1;
    localparam int CNT_W  = $clog2(SEG_COUNT + 1);
    localparam int ADDR_W = ID_W + OFF_W;
    localparam int REG_AW = $clog2(REG_COUNT);

    typedef enum logic [2:0] {
        ST_EXEC   = 3'd0,
        ST_HALT   = 3'd1,
        ST_WAIT   = 3'd2,
        ST_FAULT  = 3'd3,
        ST_LOADED = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        F_NONE       = 4'd0,
        F_BAD_OP     = 4'd1,
        F_DIV_ZERO   = 4'd2,
        F_UNMAPPED   = 4'd3,
        F_OFFSET     = 4'd4,
        F_OUT_RANGE  = 4'd5,
        F_NO_ID      = 4'd6,
        F_TOO_LARGE  = 4'd7,
        F_UNMAP_ZERO = 4'd8,
        F_PROG_FULL  = 4'd9
    } fault_t;

    typedef enum logic [3:0] {
        OP_CMOV  = 4'd0,
        OP_LOAD  = 4'd1,
        OP_STORE = 4'd2,
        OP_ADD   = 4'd3,
        OP_MUL   = 4'd4,
        OP_DIV   = 4'd5,
        OP_NAND  = 4'd6,
        OP_HALT  = 4'd7,
        OP_MAP   = 4'd8,
        OP_UNMAP = 4'd9,
        OP_OUT   = 4'd10,
        OP_IN    = 4'd11,
        OP_LOADP = 4'd12,
        OP_LOADI = 4'd13
    } opcode_t;

    localparam logic [7:0] NEWLINE = 8'd10;

    // free id stack entry before its first write
    function automatic logic [ID_W-1:0] stk_reset(input logic [ID_W-1:0] idx);
        logic [ID_W:0] v;
        v = (ID_W+1)'(SEG_COUNT - 1) - {1'b0, idx};
        return v[ID_W-1:0];
    endfunction

endpackage
`default_nettype wire

>>> src/sumc_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sumc_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module sumc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

>>> src/sumc_divider.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sumc_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sumc_divider (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire logic [sumc_pkg::WORD_W-1:0] dividend,
    input  wire logic [sumc_pkg::WORD_W-1:0] divisor,
    output logic                            done,
    output logic      [sumc_pkg::WORD_W-1:0] quotient
);
    import sumc_pkg::*;

    localparam int STEP_W = $clog2(WORD_W + 1);

    logic [WORD_W-1:0] rem_reg, rem_next;
    logic [WORD_W-1:0] quo_reg, quo_next;
    logic [WORD_W-1:0] dsr_reg, dsr_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [WORD_W:0]   trial;
    logic [WORD_W:0]   shifted;

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        shifted   = {rem_reg, quo_reg[WORD_W-1]};
        trial     = shifted - {1'b0, dsr_reg};
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
            step_next = '0;
            busy_next = 1'b1;
            done_next = 1'b0;
        end else if (busy_reg) begin
            if (!trial[WORD_W]) begin
                rem_next = trial[WORD_W-1:0];
                quo_next = {quo_reg[WORD_W-2:0], 1'b1};
            end else begin
                rem_next = shifted[WORD_W-1:0];
                quo_next = {quo_reg[WORD_W-2:0], 1'b0};
            end
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(WORD_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire

>>> src/segmented_universal_machine_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// segmented_universal_machine_core
// 32-bit segmented-memory machine: program load and single-instruction step.
// ----------------------------------------------------------------------------
// One item at a time. A load item writes the word store and then goes to its
// result. A step item runs a program fetch from the word store, three reads of
// the register file, one read of the segment length table, execute, result.
// Multiply adds a product state, divide waits on the divider (one quotient bit
// per cycle), map zero-fills all SEG_WORDS words of the slot one word a cycle,
// and load program copies the source segment word by word through the word
// store. Items on a halted or faulted machine go straight to the result.
// A result waits in the output register while the next item is taken.
// ----------------------------------------------------------------------------
module segmented_universal_machine_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_operation,
    input  wire logic [31:0] s_program_word,
    input  wire logic        s_char_valid,
    input  wire logic [7:0]  s_char_byte,
    input  wire logic        s_char_eof,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic      [2:0]  m_status,
    output logic      [3:0]  m_fault_code,
    output logic             m_out_valid,
    output logic      [7:0]  m_out_byte,
    output logic      [31:0] m_program_counter
);
    import sumc_pkg::*;

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_FETCH = 13'b0000000000010,
        S_RDB   = 13'b0000000000100,
        S_RDC   = 13'b0000000001000,
        S_RDA   = 13'b0000000010000,
        S_EXEC  = 13'b0000000100000,
        S_LOADW = 13'b0000001000000,
        S_MUL   = 13'b0000010000000,
        S_DIV   = 13'b0000100000000,
        S_FILL  = 13'b0001000000000,
        S_COPY  = 13'b0010000000000,
        S_RESP  = 13'b0100000000000,
        S_UNUSED = 13'b1000000000000
    } state_t;

    state_t            state_reg, state_next;
    logic [WORD_W-1:0] pc_reg, pc_next;
    logic [LEN_W-1:0]  len0_reg, len0_next;
    logic              halt_reg, halt_next;
    logic              stop_reg, stop_next;
    fault_t            lfault_reg, lfault_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [SEG_COUNT-1:0] mapped_reg;
    logic [SEG_COUNT-1:0] stk_vld_reg;
    logic [REG_COUNT-1:0] reg_vld_reg;
    logic              rrv_reg;

    logic [WORD_W-1:0] inst_reg, inst_next;
    logic [WORD_W-1:0] ra_reg, ra_next;
    logic [WORD_W-1:0] rb_reg, rb_next;
    logic [WORD_W-1:0] rc_reg, rc_next;
    logic [WORD_W-1:0] segid_reg, segid_next;
    logic [WORD_W-1:0] prod_reg, prod_next;
    logic              cv_reg, cv_next;
    logic [7:0]        cb_reg, cb_next;
    logic              ce_reg, ce_next;
    logic [LEN_W-1:0]  idx_reg, idx_next;
    logic [OFF_W-1:0]  widx_reg, widx_next;
    logic              pend_reg, pend_next;
    logic [LEN_W-1:0]  cplen_reg, cplen_next;
    logic [ID_W-1:0]   mapid_reg, mapid_next;

    status_t           res_status_reg, res_status_next;
    fault_t            res_code_reg, res_code_next;
    logic              res_ov_reg, res_ov_next;
    logic [7:0]        res_ob_reg, res_ob_next;

    logic              m_valid_reg, m_valid_next;
    status_t           m_status_reg, m_status_next;
    fault_t            m_code_reg, m_code_next;
    logic              m_ov_reg, m_ov_next;
    logic [7:0]        m_ob_reg, m_ob_next;
    logic [WORD_W-1:0] m_pc_reg, m_pc_next;

    logic              wram_we;
    logic [ADDR_W-1:0] wram_waddr, wram_raddr;
    logic [WORD_W-1:0] wram_wdata, wram_rdata;
    logic              reg_we;
    logic [REG_AW-1:0] reg_waddr, reg_raddr;
    logic [WORD_W-1:0] reg_wdata, reg_rdata, reg_rd;
    logic              len_we;
    logic [ID_W-1:0]   len_waddr, len_raddr;
    logic [LEN_W-1:0]  len_wdata, len_rdata;
    logic              stk_we;
    logic [ID_W-1:0]   stk_waddr, stk_raddr;
    logic [ID_W-1:0]   stk_wdata, stk_rdata;
    logic              map_set, map_clr;
    logic [ID_W-1:0]   map_id;

    logic              div_start, div_done;
    logic [WORD_W-1:0] div_q;

    logic              fin;
    status_t           fin_status;
    fault_t            fin_code;
    logic              fin_ov;
    logic [7:0]        fin_ob;

    opcode_t           op;
    logic [REG_AW-1:0] fa, fb, fc, fi;
    logic              seg_ok;
    logic [LEN_W-1:0]  seglen;
    logic [ID_W-1:0]   top_idx, top_id;
    logic [WORD_W-1:0] pc_inc;

    sumc_ram #(.WIDTH(WORD_W), .DEPTH(SEG_COUNT * SEG_WORDS)) u_word_ram (
        .aclk(aclk), .we(wram_we), .waddr(wram_waddr), .wdata(wram_wdata),
        .raddr(wram_raddr), .rdata(wram_rdata)
    );

    sumc_ram #(.WIDTH(WORD_W), .DEPTH(REG_COUNT)) u_reg_ram (
        .aclk(aclk), .we(reg_we), .waddr(reg_waddr), .wdata(reg_wdata),
        .raddr(reg_raddr), .rdata(reg_rdata)
    );

    sumc_ram #(.WIDTH(LEN_W), .DEPTH(SEG_COUNT)) u_len_ram (
        .aclk(aclk), .we(len_we), .waddr(len_waddr), .wdata(len_wdata),
        .raddr(len_raddr), .rdata(len_rdata)
    );

    sumc_ram #(.WIDTH(ID_W), .DEPTH(SEG_COUNT)) u_stack_ram (
        .aclk(aclk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
        .raddr(stk_raddr), .rdata(stk_rdata)
    );

    sumc_divider u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .dividend(rb_reg), .divisor(rc_reg), .done(div_done), .quotient(div_q)
    );

    assign op      = opcode_t'(inst_reg[31:28]);
    assign fa      = inst_reg[8:6];
    assign fb      = inst_reg[5:3];
    assign fc      = inst_reg[2:0];
    assign fi      = inst_reg[27:25];
    assign reg_rd  = rrv_reg ? reg_rdata : '0;
    assign pc_inc  = pc_reg + 32'd1;
    assign seg_ok  = (segid_reg < 32'(SEG_COUNT)) && mapped_reg[segid_reg[ID_W-1:0]];
    assign seglen  = (segid_reg[ID_W-1:0] == '0) ? len0_reg :
                     (mapped_reg[segid_reg[ID_W-1:0]] ? len_rdata : '0);
    assign top_idx = cnt_reg[ID_W-1:0] - 1'b1;
    assign top_id  = stk_vld_reg[top_idx] ? stk_rdata : stk_reset(top_idx);
    assign prod_next = rb_reg * rc_reg;
    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next  = state_reg;
        pc_next     = pc_reg;
        len0_next   = len0_reg;
        halt_next   = halt_reg;
        stop_next   = stop_reg;
        lfault_next = lfault_reg;
        cnt_next    = cnt_reg;
        inst_next   = inst_reg;
        ra_next     = ra_reg;
        rb_next     = rb_reg;
        rc_next     = rc_reg;
        segid_next  = segid_reg;
        cv_next     = cv_reg;
        cb_next     = cb_reg;
        ce_next     = ce_reg;
        idx_next    = idx_reg;
        widx_next   = widx_reg;
        pend_next   = pend_reg;
        cplen_next  = cplen_reg;
        mapid_next  = mapid_reg;
        res_status_next = res_status_reg;
        res_code_next   = res_code_reg;
        res_ov_next     = res_ov_reg;
        res_ob_next     = res_ob_reg;
        m_valid_next  = m_valid_reg;
        m_status_next = m_status_reg;
        m_code_next   = m_code_reg;
        m_ov_next     = m_ov_reg;
        m_ob_next     = m_ob_reg;
        m_pc_next     = m_pc_reg;

        wram_we    = 1'b0;
        wram_waddr = '0;
        wram_wdata = '0;
        wram_raddr = '0;
        reg_we     = 1'b0;
        reg_waddr  = '0;
        reg_wdata  = '0;
        reg_raddr  = '0;
        len_we     = 1'b0;
        len_waddr  = '0;
        len_wdata  = '0;
        len_raddr  = '0;
        stk_we     = 1'b0;
        stk_waddr  = '0;
        stk_wdata  = '0;
        stk_raddr  = '0;
        map_set    = 1'b0;
        map_clr    = 1'b0;
        map_id     = '0;
        div_start  = 1'b0;
        fin        = 1'b0;
        fin_status = ST_EXEC;
        fin_code   = F_NONE;
        fin_ov     = 1'b0;
        fin_ob     = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cv_next = s_char_valid;
                    cb_next = s_char_byte;
                    ce_next = s_char_eof;
                    if (halt_reg) begin
                        fin = 1'b1;
                        fin_status = ST_HALT;
                    end else if (stop_reg) begin
                        fin = 1'b1;
                        fin_status = ST_FAULT;
                        fin_code = lfault_reg;
                    end else if (!s_operation) begin
                        if (len0_reg >= LEN_W'(SEG_WORDS)) begin
                            fin = 1'b1;
                            fin_status = ST_FAULT;
                            fin_code = F_PROG_FULL;
                        end else begin
                            wram_we    = 1'b1;
                            wram_waddr = {ID_W'(0), len0_reg[OFF_W-1:0]};
                            wram_wdata = s_program_word;
                            len0_next  = len0_reg + 1'b1;
                            fin = 1'b1;
                            fin_status = ST_LOADED;
                        end
                    end else if (pc_reg >= 32'(len0_reg)) begin
                        fin = 1'b1;
                        fin_status = ST_FAULT;
                        fin_code = F_OFFSET;
                    end else begin
                        wram_raddr = {ID_W'(0), pc_reg[OFF_W-1:0]};
                        state_next = S_FETCH;
                    end
                end
            end
            S_FETCH: begin
                inst_next  = wram_rdata;
                reg_raddr  = wram_rdata[5:3];
                state_next = S_RDB;
            end
            S_RDB: begin
                rb_next    = reg_rd;
                reg_raddr  = fc;
                state_next = S_RDC;
            end
            S_RDC: begin
                rc_next    = reg_rd;
                reg_raddr  = fa;
                state_next = S_RDA;
            end
            S_RDA: begin
                ra_next = reg_rd;
                if (op == OP_STORE) begin
                    segid_next = reg_rd;
                end else if (op == OP_UNMAP) begin
                    segid_next = rc_reg;
                end else begin
                    segid_next = rb_reg;
                end
                len_raddr  = segid_next[ID_W-1:0];
                stk_raddr  = top_idx;
                state_next = S_EXEC;
            end
            S_EXEC: begin
                unique case (op)
                    OP_CMOV: begin
                        if (rc_reg != '0) begin
                            reg_we = 1'b1;
                            reg_waddr = fa;
                            reg_wdata = rb_reg;
                        end
                        pc_next = pc_inc;
                        fin = 1'b1;
                    end
                    OP_LOAD: begin
                        if (!seg_ok) begin
                            fin = 1'b1;
                            fin_status = ST_FAULT;
                            fin_code = F_UNMAPPED;
                        end else if (rc_reg >= 32'(seglen)) begin
                            fin = 1'b1;
                            fin_status = ST_FAULT;
                            fin_code = F_OFFSET;
                        end else begin
                            wram_raddr = {segid_reg[ID_W-1:0], rc_reg[OFF_W-1:0]};
                            state_next = S_LOADW;
                        end
                    end
                    OP_STORE: begin
                        if (!seg_ok) begin
                            fin = 1'b1;
                            fin_status = ST_FAULT;
                            fin_code = F_UNMAPPED;
                        end else if (rb_reg >= 32'(seglen)) begin
                            fin = 1'b1;
                            fin_status = ST_FAULT;
                            fin_code = F_OFFSET;
                        end else begin
                            wram_we    = 1'b1;
                            wram_waddr = {segid_reg[ID_W-1:0], rb_reg[OFF_W-1:0]};
                            wram_wdata = rc_reg;
                            pc_next = pc_inc;
                            fin = 1'b1;
                        end
                    end
                    OP_ADD: begin
                        reg_we = 1'b1;
                        reg_waddr = fa;
                        reg_wdata = rb_reg + rc_reg;
                        pc_next = pc_inc;
                        fin = 1'b1;
                    end
                    OP_MUL: begin
                        state_next = S_MUL;
                    end
                    OP_DIV: begin
                        if (rc_reg == '0) begin
                            fin = 1'b1;
                            fin_status = ST_FAULT;
                            fin_code = F_DIV_ZERO;
                        end else begin
                            div_start  = 1'b1;
                            state_next = S_DIV;
                        end
                    end
                    OP_NAND: begin
                        reg_we = 1'b1;
                        reg_waddr = fa;
                        reg_wdata = ~(rb_reg & rc_reg);
                        pc_next = pc_inc;
                        fin = 1'b1;
                    end
                    OP_HALT: begin
                        halt_next = 1'b1;
                        pc_next = pc_inc;
                        fin = 1'b1;
                        fin_status = ST_HALT;
                    end
                    OP_MAP: begin
                        if (rc_reg > 32'(SEG_WORDS)) begin
                            fin = 1'b1;
                            fin_status = ST_FAULT;
                            fin_code = F_TOO_LARGE;
                        end else if (cnt_reg == '0) begin
                            fin = 1'b1;
                            fin_status = ST_FAULT;
                            fin_code = F_NO_ID;
                        end else begin
                            cnt_next   = cnt_reg - 1'b1;
                            mapid_next = top_id;
                            idx_next   = '0;
                            state_next = S_FILL;
                        end
                    end
                    OP_UNMAP: begin
                        if (rc_reg == '0) begin
                            fin = 1'b1;
                            fin_status = ST_FAULT;
                            fin_code = F_UNMAP_ZERO;
                        end else if (!seg_ok) begin
                            fin = 1'b1;
                            fin_status = ST_FAULT;
                            fin_code = F_UNMAPPED;
                        end else begin
                            map_clr = 1'b1;
                            map_id  = rc_reg[ID_W-1:0];
                            if (cnt_reg < CNT_W'(SEG_COUNT)) begin
                                stk_we    = 1'b1;
                                stk_waddr = cnt_reg[ID_W-1:0];
                                stk_wdata = rc_reg[ID_W-1:0];
                                cnt_next  = cnt_reg + 1'b1;
                            end
                            pc_next = pc_inc;
                            fin = 1'b1;
                        end
                    end
                    OP_OUT: begin
                        if (rc_reg > 32'd255) begin
                            fin = 1'b1;
                            fin_status = ST_FAULT;
                            fin_code = F_OUT_RANGE;
                        end else begin
                            pc_next = pc_inc;
                            fin = 1'b1;
                            fin_ov = 1'b1;
                            fin_ob = rc_reg[7:0];
                        end
                    end
                    OP_IN: begin
                        if (!cv_reg || (!ce_reg && cb_reg == NEWLINE)) begin
                            fin = 1'b1;
                            fin_status = ST_WAIT;
                        end else begin
                            reg_we = 1'b1;
                            reg_waddr = fc;
                            reg_wdata = ce_reg ? '1 : {24'd0, cb_reg};
                            pc_next = pc_inc;
                            fin = 1'b1;
                        end
                    end
                    OP_LOADP: begin
                        if (rb_reg == '0) begin
                            pc_next = rc_reg;
                            fin = 1'b1;
                        end else if (!seg_ok) begin
                            fin = 1'b1;
                            fin_status = ST_FAULT;
                            fin_code = F_UNMAPPED;
                        end else begin
                            cplen_next = seglen;
                            idx_next   = '0;
                            pend_next  = 1'b0;
                            state_next = S_COPY;
                        end
                    end
                    OP_LOADI: begin
                        reg_we = 1'b1;
                        reg_waddr = fi;
                        reg_wdata = {7'd0, inst_reg[24:0]};
                        pc_next = pc_inc;
                        fin = 1'b1;
                    end
                    default: begin
                        fin = 1'b1;
                        fin_status = ST_FAULT;
                        fin_code = F_BAD_OP;
                    end
                endcase
            end
            S_LOADW: begin
                reg_we = 1'b1;
                reg_waddr = fa;
                reg_wdata = wram_rdata;
                pc_next = pc_inc;
                fin = 1'b1;
            end
            S_MUL: begin
                reg_we = 1'b1;
                reg_waddr = fa;
                reg_wdata = prod_reg;
                pc_next = pc_inc;
                fin = 1'b1;
            end
            S_DIV: begin
                if (div_done) begin
                    reg_we = 1'b1;
                    reg_waddr = fa;
                    reg_wdata = div_q;
                    pc_next = pc_inc;
                    fin = 1'b1;
                end
            end
            S_FILL: begin
                wram_we    = 1'b1;
                wram_waddr = {mapid_reg, idx_reg[OFF_W-1:0]};
                wram_wdata = '0;
                idx_next   = idx_reg + 1'b1;
                if (idx_reg[OFF_W-1:0] == '1) begin
                    len_we    = 1'b1;
                    len_waddr = mapid_reg;
                    len_wdata = rc_reg[LEN_W-1:0];
                    map_set   = 1'b1;
                    map_id    = mapid_reg;
                    if (mapid_reg == '0) begin
                        len0_next = rc_reg[LEN_W-1:0];
                    end
                    reg_we = 1'b1;
                    reg_waddr = fb;
                    reg_wdata = WORD_W'(mapid_reg);
                    pc_next = pc_inc;
                    fin = 1'b1;
                end
            end
            S_COPY: begin
                if (pend_reg) begin
                    wram_we    = 1'b1;
                    wram_waddr = {ID_W'(0), widx_reg};
                    wram_wdata = wram_rdata;
                end
                if (idx_reg < cplen_reg) begin
                    wram_raddr = {segid_reg[ID_W-1:0], idx_reg[OFF_W-1:0]};
                    widx_next  = idx_reg[OFF_W-1:0];
                    pend_next  = 1'b1;
                    idx_next   = idx_reg + 1'b1;
                end else begin
                    pend_next = 1'b0;
                    if (!pend_reg) begin
                        len0_next = cplen_reg;
                        pc_next = rc_reg;
                        fin = 1'b1;
                    end
                end
            end
            S_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_code_next   = res_code_reg;
                    m_ov_next     = res_ov_reg;
                    m_ob_next     = res_ob_reg;
                    m_pc_next     = pc_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (fin) begin
            res_status_next = fin_status;
            res_code_next   = fin_code;
            res_ov_next     = fin_ov;
            res_ob_next     = fin_ob;
            state_next      = S_RESP;
            if (fin_status == ST_FAULT) begin
                stop_next   = 1'b1;
                lfault_next = fin_code;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            pc_reg      <= '0;
            len0_reg    <= '0;
            halt_reg    <= 1'b0;
            stop_reg    <= 1'b0;
            lfault_reg  <= F_NONE;
            cnt_reg     <= CNT_W'(SEG_COUNT - 1);
            mapped_reg  <= SEG_COUNT'(1);
            stk_vld_reg <= '0;
            reg_vld_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pc_reg      <= pc_next;
            len0_reg    <= len0_next;
            halt_reg    <= halt_next;
            stop_reg    <= stop_next;
            lfault_reg  <= lfault_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
            if (map_set) begin
                mapped_reg[map_id] <= 1'b1;
            end
            if (map_clr) begin
                mapped_reg[map_id] <= 1'b0;
            end
            if (stk_we) begin
                stk_vld_reg[stk_waddr] <= 1'b1;
            end
            if (reg_we) begin
                reg_vld_reg[reg_waddr] <= 1'b1;
            end
        end
        rrv_reg        <= reg_vld_reg[reg_raddr];
        inst_reg       <= inst_next;
        ra_reg         <= ra_next;
        rb_reg         <= rb_next;
        rc_reg         <= rc_next;
        segid_reg      <= segid_next;
        prod_reg       <= prod_next;
        cv_reg         <= cv_next;
        cb_reg         <= cb_next;
        ce_reg         <= ce_next;
        idx_reg        <= idx_next;
        widx_reg       <= widx_next;
        pend_reg       <= pend_next;
        cplen_reg      <= cplen_next;
        mapid_reg      <= mapid_next;
        res_status_reg <= res_status_next;
        res_code_reg   <= res_code_next;
        res_ov_reg     <= res_ov_next;
        res_ob_reg     <= res_ob_next;
        m_status_reg   <= m_status_next;
        m_code_reg     <= m_code_next;
        m_ov_reg       <= m_ov_next;
        m_ob_reg       <= m_ob_next;
        m_pc_reg       <= m_pc_next;
    end

    assign m_valid           = m_valid_reg;
    assign m_status          = m_status_reg;
    assign m_fault_code      = m_code_reg;
    assign m_out_valid       = m_ov_reg;
    assign m_out_byte        = m_ob_reg;
    assign m_program_counter = m_pc_reg;

endmodule
`default_nettype wire

>>> src/sumc_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sumc_checker
// Port-level checks of the machine core, bound to the top level.
// ----------------------------------------------------------------------------
module sumc_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [2:0]  m_status,
    input wire logic [3:0]  m_fault_code,
    input wire logic        m_out_valid,
    input wire logic [7:0]  m_out_byte,
    input wire logic [31:0] m_program_counter
);
    import sumc_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) &&
        $stable(m_fault_code) && $stable(m_program_counter))
        else $error("result item changed while stalled");

    a_code_none: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_FAULT |-> m_fault_code == F_NONE)
        else $error("fault code on a non-fault item");

    a_code_set: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_FAULT |-> m_fault_code != F_NONE)
        else $error("fault item without a code");

    a_out_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_out_valid |-> m_status == ST_EXEC)
        else $error("character emitted on a non-executed item");

    a_out_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_out_valid |-> m_out_byte == 8'd0)
        else $error("byte without output");

endmodule

bind segmented_universal_machine_core sumc_checker u_sumc_checker (.*);
`default_nettype wire
